// ----- sv/kbr_pkg.sv -----
// Shared types and constants for the keyboard report builder.
package kbr_pkg;

   localparam int SLOT_COUNT_DEF   = 6;
   localparam int BITMAP_BYTES_DEF = 32;

   // Widest store address; the store uses as many low bits as its depth needs.
   localparam int ADDR_W = 5;
   localparam int KEY_W  = 8;

   // Usage codes 0xE0 through 0xE7 share this upper field.
   localparam logic [4:0] MOD_PREFIX = 5'b11100;

   localparam logic KIND_SET   = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_BYTE,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_data;
   } store_req_type;

endpackage

// ----- sv/hid_keyboard_report_builder_core.sv -----
// Top level of the keyboard report builder: mode register, sequencer and key store.
//
// Each request on the req_ channel either sets a key's pressed state or asks
// whether a key is held. Modifier usages 0xE0..0xE7 live in a modifier byte;
// other nonzero keys go to the key store, read as SLOT_COUNT slots
// (csr_wr_data = 0) or as a key bitmap (csr_wr_data = 1). The user must write
// the mode register with csr_wr_en only while no request is in flight; the
// block itself does not enforce this. One request is handled at a time.
// Keycode zero, a modifier or an out-of-range bitmap key go from decode
// straight to the response; a bitmap key reads its store byte and, for a set,
// writes it back; in slot mode the slot scan reads one store entry per cycle
// until a hit or the last slot. The input is ready again the cycle after the
// response is loaded.
// The response waits in its output register while rsp_ready is low; the next
// request may be accepted and worked on meanwhile, and its response is held
// back until the register is free.
// Reset clears the modifier byte, the mode register and the store's entry
// valid bits, so every key reads as released; no clearing pass is needed.
module hid_keyboard_report_builder_core #(
   parameter int SLOT_COUNT   = kbr_pkg::SLOT_COUNT_DEF,
   parameter int BITMAP_BYTES = kbr_pkg::BITMAP_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic                      csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic                      req_pressed,
   input  logic [kbr_pkg::KEY_W-1:0] req_keycode,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_status,
   output logic                      rsp_key_down,
   output logic [kbr_pkg::KEY_W-1:0] rsp_modifier_byte
);
   import kbr_pkg::*;

   logic             nkro_mode_ff, nkro_mode_in;
   store_req_type    store_req;
   logic [KEY_W-1:0] rd_data;

   assign nkro_mode_in = csr_wr_en ? csr_wr_data : nkro_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nkro_mode_ff <= 1'b0;
      end else begin
         nkro_mode_ff <= nkro_mode_in;
      end
   end

   kbr_seq #(
      .SLOT_COUNT   (SLOT_COUNT),
      .BITMAP_BYTES (BITMAP_BYTES)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .nkro_mode         (nkro_mode_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_pressed       (req_pressed),
      .req_keycode       (req_keycode),
      .rd_data           (rd_data),
      .store_req         (store_req),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_key_down      (rsp_key_down),
      .rsp_modifier_byte (rsp_modifier_byte)
   );

   kbr_store #(
      .DEPTH (BITMAP_BYTES)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   // A request is worked on alone: no second acceptance right after one.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another was in flight");

   // A key can only be reported held when the lookup succeeded.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_key_down) |-> (rsp_status == STATUS_DONE))
      else $error("key reported held with a failing status");

   // The store is never written while the block waits for a request.
   assert property (@(posedge clock) disable iff (reset)
      store_req.wr_en |-> !req_ready)
      else $error("store write while idle");

   // Store reads and writes never target the same cycle's pair of ports.
   assert property (@(posedge clock) disable iff (reset)
      !(store_req.wr_en && store_req.rd_en))
      else $error("store read and write in the same cycle");

endmodule

// ----- sv/kbr_store.sv -----
// Key store: slot bytes or key bitmap, one read and one write port per cycle.
module kbr_store #(
   parameter int DEPTH = kbr_pkg::BITMAP_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kbr_pkg::store_req_type store_req,
   output logic [kbr_pkg::KEY_W-1:0] rd_data
);
   import kbr_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [KEY_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [KEY_W-1:0] rd_data_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr[AW-1:0]] <= store_req.wr_data;
      end
      if (store_req.rd_en) begin
         rd_data_ff <= mem[store_req.rd_addr[AW-1:0]];
      end
   end

   // An entry that was never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (store_req.wr_en) begin
            valid_ff[store_req.wr_addr[AW-1:0]] <= 1'b1;
         end
         if (store_req.rd_en) begin
            rd_valid_ff <= valid_ff[store_req.rd_addr[AW-1:0]];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- sv/kbr_seq.sv -----
// Request sequencer: decodes a key event, scans or updates the store, builds the response.
module kbr_seq #(
   parameter int SLOT_COUNT   = kbr_pkg::SLOT_COUNT_DEF,
   parameter int BITMAP_BYTES = kbr_pkg::BITMAP_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      nkro_mode,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_kind,
   input  logic                      req_pressed,
   input  logic [kbr_pkg::KEY_W-1:0] req_keycode,
   input  logic [kbr_pkg::KEY_W-1:0] rd_data,
   output kbr_pkg::store_req_type    store_req,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_status,
   output logic                      rsp_key_down,
   output logic [kbr_pkg::KEY_W-1:0] rsp_modifier_byte
);
   import kbr_pkg::*;

   localparam int SW = $clog2(SLOT_COUNT + 1);

   seq_state_type     state_ff, state_in;
   logic              kind_ff, kind_in;
   logic              pressed_ff, pressed_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  mod_ff, mod_in;
   logic [SW-1:0]     idx_ff, idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [ADDR_W-1:0] cmp_addr_ff, cmp_addr_in;
   logic              status_ff, status_in;
   logic              down_ff, down_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_key_down_ff, rsp_key_down_in;
   logic [KEY_W-1:0]  rsp_modifier_byte_ff, rsp_modifier_byte_in;

   logic             is_zero;
   logic             is_mod;
   logic [KEY_W-1:0] key_bit;
   logic [4:0]       byte_idx;
   logic             byte_oob;
   logic [KEY_W-1:0] slot_target;
   logic             slot_hit;
   logic             scan_last;
   logic             issue;
   logic             out_free;

   assign is_zero   = (key_ff == '0);
   assign is_mod    = (key_ff[7:3] == MOD_PREFIX);
   assign key_bit   = KEY_W'(1) << key_ff[2:0];
   assign byte_idx  = key_ff[7:3];
   assign byte_oob  = ({1'b0, byte_idx} >= 6'(BITMAP_BYTES));
   // A press looks for an empty slot; release and query look for the key itself.
   assign slot_target = (kind_ff == KIND_SET && pressed_ff) ? '0 : key_ff;
   assign slot_hit  = cmp_vld_ff && (rd_data == slot_target);
   assign scan_last = cmp_vld_ff && (idx_ff == SW'(SLOT_COUNT));
   assign issue     = (state_ff == ST_SCAN) && (idx_ff < SW'(SLOT_COUNT)) && !slot_hit;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (is_zero || is_mod || (nkro_mode && byte_oob)) begin
               state_in = ST_DONE;
            end else if (nkro_mode) begin
               state_in = ST_BYTE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (slot_hit || scan_last) state_in = ST_DONE;
         end
         ST_BYTE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      kind_in              = kind_ff;
      pressed_in           = pressed_ff;
      key_in               = key_ff;
      mod_in               = mod_ff;
      idx_in               = idx_ff;
      cmp_vld_in           = 1'b0;
      cmp_addr_in          = cmp_addr_ff;
      status_in            = status_ff;
      down_in              = down_ff;
      rsp_valid_in         = rsp_valid_ff && !rsp_ready;
      rsp_status_in        = rsp_status_ff;
      rsp_key_down_in      = rsp_key_down_ff;
      rsp_modifier_byte_in = rsp_modifier_byte_ff;
      store_req            = '0;
      req_ready            = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in    = req_kind;
               pressed_in = req_pressed;
               key_in     = req_keycode;
            end
         end
         ST_DECODE: begin
            idx_in = '0;
            if (is_zero) begin
               status_in = STATUS_FAIL;
               down_in   = 1'b0;
            end else if (is_mod) begin
               status_in = STATUS_DONE;
               if (kind_ff == KIND_QUERY) begin
                  down_in = |(mod_ff & key_bit);
               end else begin
                  down_in = 1'b0;
                  mod_in  = pressed_ff ? (mod_ff | key_bit) : (mod_ff & ~key_bit);
               end
            end else if (nkro_mode) begin
               if (byte_oob) begin
                  status_in = STATUS_FAIL;
                  down_in   = 1'b0;
               end else begin
                  store_req.rd_en   = 1'b1;
                  store_req.rd_addr = ADDR_W'(byte_idx);
               end
            end
         end
         ST_SCAN: begin
            // Reads are issued one slot ahead of the compare.
            cmp_vld_in = issue;
            if (issue) begin
               store_req.rd_en   = 1'b1;
               store_req.rd_addr = ADDR_W'(idx_ff);
               cmp_addr_in       = ADDR_W'(idx_ff);
               idx_in            = idx_ff + SW'(1);
            end
            if (slot_hit) begin
               status_in = STATUS_DONE;
               down_in   = (kind_ff == KIND_QUERY);
               if (kind_ff == KIND_SET) begin
                  store_req.wr_en   = 1'b1;
                  store_req.wr_addr = cmp_addr_ff;
                  store_req.wr_data = pressed_ff ? key_ff : '0;
               end
            end else if (scan_last) begin
               status_in = (kind_ff == KIND_QUERY) ? STATUS_DONE : STATUS_FAIL;
               down_in   = 1'b0;
            end
         end
         ST_BYTE: begin
            status_in = STATUS_DONE;
            if (kind_ff == KIND_QUERY) begin
               down_in = |(rd_data & key_bit);
            end else begin
               down_in           = 1'b0;
               store_req.wr_en   = 1'b1;
               store_req.wr_addr = ADDR_W'(byte_idx);
               store_req.wr_data = pressed_ff ? (rd_data | key_bit) : (rd_data & ~key_bit);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_status_in        = status_ff;
               rsp_key_down_in      = down_ff;
               rsp_modifier_byte_in = mod_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mod_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mod_ff       <= mod_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff              <= kind_in;
      pressed_ff           <= pressed_in;
      key_ff               <= key_in;
      idx_ff               <= idx_in;
      cmp_addr_ff          <= cmp_addr_in;
      status_ff            <= status_in;
      down_ff              <= down_in;
      rsp_status_ff        <= rsp_status_in;
      rsp_key_down_ff      <= rsp_key_down_in;
      rsp_modifier_byte_ff <= rsp_modifier_byte_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_key_down      = rsp_key_down_ff;
   assign rsp_modifier_byte = rsp_modifier_byte_ff;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the keyboard report builder core.
module tb;
   import kbr_pkg::*;

   localparam logic MODE_SLOTS  = 1'b0;
   localparam logic MODE_BITMAP = 1'b1;
   localparam int   STALL_CYCLES = 300;
   localparam int   CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic             status;
      logic             key_down;
      logic [KEY_W-1:0] modifier;
   } report_resp_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic             csr_wr_data = 1'b0;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_kind = KIND_SET;
   logic             req_pressed = 1'b0;
   logic [KEY_W-1:0] req_keycode = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_status;
   logic             rsp_key_down;
   logic [KEY_W-1:0] rsp_modifier_byte;

   // Shadow copy of the report state.
   logic [7:0]       shadow_modifiers;
   logic [7:0]       shadow_store [0:31];
   logic             shadow_mode;

   report_resp_type  pending_reports [$];
   int               fail_count = 0;
   int               cycle_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               stall_requests = 0;
   int               stall_granted = 0;
   int               stall_left = 0;

   hid_keyboard_report_builder_core uut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_pressed       (req_pressed),
      .req_keycode       (req_keycode),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_key_down      (rsp_key_down),
      .rsp_modifier_byte (rsp_modifier_byte)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic report_resp_type predict_report(input logic kind, input logic pressed,
                                                      input logic [KEY_W-1:0] key);
      report_resp_type r;
      logic [7:0]      mask;
      logic [4:0]      idx;
      bit              done;
      int              i;
      r.status   = STATUS_DONE;
      r.key_down = 1'b0;
      mask = 8'h01 << key[2:0];
      idx  = key[7:3];
      done = 1'b0;
      if (key == '0) begin
         r.status = STATUS_FAIL;
      end else if (key[7:3] == MOD_PREFIX) begin
         if (kind == KIND_QUERY) begin
            r.key_down = |(shadow_modifiers & mask);
         end else if (pressed) begin
            shadow_modifiers = shadow_modifiers | mask;
         end else begin
            shadow_modifiers = shadow_modifiers & ~mask;
         end
      end else if (shadow_mode == MODE_SLOTS) begin
         if (kind == KIND_QUERY) begin
            for (i = 0; i < SLOT_COUNT_DEF; i++)
               if (shadow_store[i] == key) r.key_down = 1'b1;
         end else begin
            // A press takes the first empty slot even when the key is already held.
            for (i = 0; i < SLOT_COUNT_DEF; i++) begin
               if (!done && (pressed ? (shadow_store[i] == 8'h00) : (shadow_store[i] == key))) begin
                  shadow_store[i] = pressed ? key : 8'h00;
                  done = 1'b1;
               end
            end
            if (!done) r.status = STATUS_FAIL;
         end
      end else if (int'(idx) >= BITMAP_BYTES_DEF) begin
         r.status = STATUS_FAIL;
      end else if (kind == KIND_QUERY) begin
         r.key_down = |(shadow_store[idx] & mask);
      end else if (pressed) begin
         shadow_store[idx] = shadow_store[idx] | mask;
      end else begin
         shadow_store[idx] = shadow_store[idx] & ~mask;
      end
      r.modifier = shadow_modifiers;
      return r;
   endfunction

   // Response checker.
   always @(posedge clock) begin
      report_resp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_key_down !== want.key_down) begin
               $error("key_down: expected %0d, actual %0d", want.key_down, rsp_key_down);
               fail_count++;
            end
            if (rsp_modifier_byte !== want.modifier) begin
               $error("modifier_byte: expected %h, actual %h", want.modifier, rsp_modifier_byte);
               fail_count++;
            end
         end
      end
   end

   // Response side: random idling, plus a long hold-off when the stall test asks.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (stall_granted != stall_requests) begin
         stall_granted = stall_requests;
         stall_left = STALL_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_request(input logic kind, input logic pressed, input logic [KEY_W-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_pressed <= pressed;
      req_keycode <= key;
      do @(posedge clock); while (!req_ready);
      pending_reports.push_back(predict_report(kind, pressed, key));
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_mode = mode;
   endtask

   task automatic send_random_event();
      int               pick;
      logic [KEY_W-1:0] key;
      pick = $urandom_range(99);
      if (pick < 8)
         key = 8'h00;
      else if (pick < 20)
         key = {MOD_PREFIX, 3'($urandom_range(7))};
      else if (pick < 85)
         key = 8'h04 + 8'($urandom_range(9)); // small pool so slots fill and releases match
      else
         key = 8'($urandom_range(255));
      send_request(($urandom_range(99) < 30) ? KIND_QUERY : KIND_SET,
                   1'($urandom_range(1)), key);
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_mode(MODE_SLOTS);
      send_request(KIND_SET,   1'b1, 8'h00);
      send_request(KIND_QUERY, 1'b0, 8'h00);
      send_request(KIND_SET,   1'b1, 8'hE0);
      send_request(KIND_SET,   1'b1, 8'hE7);
      send_request(KIND_QUERY, 1'b1, 8'hE7);
      send_request(KIND_QUERY, 1'b0, 8'hE3);
      send_request(KIND_SET,   1'b0, 8'hE0);
      send_request(KIND_SET,   1'b0, 8'h04);
      send_request(KIND_SET,   1'b1, 8'h04);
      send_request(KIND_SET,   1'b1, 8'h05);
      send_request(KIND_SET,   1'b1, 8'hFF);
      send_request(KIND_SET,   1'b1, 8'h04);
      send_request(KIND_SET,   1'b1, 8'h01);
      send_request(KIND_SET,   1'b1, 8'h80);
      send_request(KIND_SET,   1'b1, 8'h06);
      send_request(KIND_QUERY, 1'b0, 8'hFF);
      send_request(KIND_SET,   1'b0, 8'h04);
      send_request(KIND_QUERY, 1'b0, 8'h04);
      send_request(KIND_SET,   1'b0, 8'hE7);
      // The slot contents are now read back as bitmap bytes.
      write_mode(MODE_BITMAP);
      send_request(KIND_QUERY, 1'b0, 8'h08);
      send_request(KIND_SET,   1'b1, 8'hFF);
      send_request(KIND_QUERY, 1'b0, 8'hFF);
      send_request(KIND_SET,   1'b0, 8'hFF);
      send_request(KIND_SET,   1'b1, 8'h01);
      send_request(KIND_QUERY, 1'b1, 8'h00);
      drain_responses();
   endtask

   task automatic test_random_traffic(input logic mode, input int send_pct, input int recv_pct,
                                      input int count);
      int n;
      write_mode(mode);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (n = 0; n < count; n++) send_random_event();
      drain_responses();
   endtask

   task automatic test_output_stall();
      int n;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_requests++;
      for (n = 0; n < 24; n++) send_random_event();
      drain_responses();
   endtask

   initial begin
      int i;
      shadow_modifiers = 8'h00;
      shadow_mode = MODE_SLOTS;
      for (i = 0; i < 32; i++) shadow_store[i] = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_traffic(MODE_SLOTS,  12, 47, 235);
      test_random_traffic(MODE_BITMAP, 12, 47, 235);
      test_output_stall();
      test_random_traffic(MODE_SLOTS,  47, 12, 235);
      test_random_traffic(MODE_BITMAP, 47, 12, 235);
      test_random_traffic(MODE_SLOTS,   0,  0, 235);
      test_random_traffic(MODE_BITMAP,  0,  0, 235);
      drain_responses();
      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
